// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// invariant
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

// File: hw/rtl/cie_pkg.sv
package cie_pkg;

   typedef enum logic [2:0] {
      CMD_UNSIGNED = 3'd0,
      CMD_DOUBLE   = 3'd1,
      CMD_TEXT_HDR = 3'd2,
      CMD_BYTES_HDR = 3'd3,
      CMD_BOOL     = 3'd4,
      CMD_ARRAY_HDR = 3'd5,
      CMD_MAP_HDR  = 3'd6,
      CMD_PAYLOAD  = 3'd7
   } cmd_type;

   localparam logic [2:0] MAJOR_UNSIGNED = 3'd0;
   localparam logic [2:0] MAJOR_BYTES    = 3'd2;
   localparam logic [2:0] MAJOR_TEXT     = 3'd3;
   localparam logic [2:0] MAJOR_ARRAY    = 3'd4;
   localparam logic [2:0] MAJOR_MAP      = 3'd5;

   localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
   localparam logic [4:0] AI_TWO_BYTES  = 5'd25;
   localparam logic [4:0] AI_FOUR_BYTES = 5'd26;
   localparam logic [4:0] AI_EIGHT_BYTES = 5'd27;

   localparam logic [7:0] HEAD_DOUBLE = 8'hfb;
   localparam logic [7:0] HEAD_TRUE   = 8'hf5;
   localparam logic [7:0] HEAD_FALSE  = 8'hf4;

   localparam int QUEUE_DEPTH = 2;

   // one token after classification: initial byte, then nfollow bytes
   // taken from the top of arg
   typedef struct packed {
      logic [7:0]  head;
      logic [3:0]  nfollow;
      logic [63:0] arg;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic {
      BK_HEAD = 1'b0,
      BK_ARG  = 1'b1
   } back_state_type;

   typedef struct packed {
      logic       arg_phase;
      logic [3:0] remaining;
   } back_stat_type;

endpackage

// File: hw/rtl/cie_front.sv
module cie_front
   import cie_pkg::*;
(
   input  logic        req_push,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_operand,
   input  logic        q_full,
   output logic        q_push,
   output desc_type    q_data
);

   logic [2:0] major;
   logic       is_head;

   assign q_push = req_push && !q_full;

   always_comb begin
      major   = MAJOR_UNSIGNED;
      is_head = 1'b1;
      case (cmd_type'(req_cmd))
         CMD_UNSIGNED:  major = MAJOR_UNSIGNED;
         CMD_TEXT_HDR:  major = MAJOR_TEXT;
         CMD_BYTES_HDR: major = MAJOR_BYTES;
         CMD_ARRAY_HDR: major = MAJOR_ARRAY;
         CMD_MAP_HDR:   major = MAJOR_MAP;
         default:       is_head = 1'b0;
      endcase
   end

   always_comb begin
      q_data.head    = 8'h00;
      q_data.nfollow = 4'd0;
      q_data.arg     = 64'd0;
      if (is_head) begin
         if (req_operand[63:5] == 59'd0 && req_operand[4:0] < AI_ONE_BYTE) begin
            q_data.head = {major, req_operand[4:0]};
         end else if (req_operand[63:8] == 56'd0) begin
            q_data.head    = {major, AI_ONE_BYTE};
            q_data.nfollow = 4'd1;
            q_data.arg     = {req_operand[7:0], 56'd0};
         end else if (req_operand[63:16] == 48'd0) begin
            q_data.head    = {major, AI_TWO_BYTES};
            q_data.nfollow = 4'd2;
            q_data.arg     = {req_operand[15:0], 48'd0};
         end else if (req_operand[63:32] == 32'd0) begin
            q_data.head    = {major, AI_FOUR_BYTES};
            q_data.nfollow = 4'd4;
            q_data.arg     = {req_operand[31:0], 32'd0};
         end else begin
            q_data.head    = {major, AI_EIGHT_BYTES};
            q_data.nfollow = 4'd8;
            q_data.arg     = req_operand;
         end
      end else begin
         case (cmd_type'(req_cmd))
            CMD_DOUBLE: begin
               q_data.head    = HEAD_DOUBLE;
               q_data.nfollow = 4'd8;
               q_data.arg     = req_operand;
            end
            CMD_BOOL: q_data.head = req_operand[0] ? HEAD_TRUE : HEAD_FALSE;
            default:  q_data.head = req_operand[7:0];
         endcase
      end
   end

endmodule

// File: hw/rtl/cie_queue.sv
module cie_queue
   import cie_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  desc_type       push_data,
   input  logic           pop,
   output desc_type       pop_data,
   output queue_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/cie_back.sv
module cie_back
   import cie_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  desc_type       q_data,
   input  logic           q_empty,
   output logic           q_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last,
   output back_stat_type  stat
);

   back_state_type state_ff, state_in;
   logic [3:0]     rem_ff, rem_in;
   logic [63:0]    shift_ff, shift_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;
   logic           slot_free;

   assign slot_free     = !out_valid_ff || rsp_pop;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last      = out_last_ff;
   assign stat.arg_phase = (state_ff == BK_ARG);
   assign stat.remaining = rem_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      if (slot_free) begin
         case (state_ff)
            BK_HEAD: begin
               if (!q_empty) begin
                  q_pop        = 1'b1;
                  out_valid_in = 1'b1;
                  out_byte_in  = q_data.head;
                  out_last_in  = (q_data.nfollow == 4'd0);
                  rem_in       = q_data.nfollow;
                  shift_in     = q_data.arg;
                  if (q_data.nfollow != 4'd0) begin
                     state_in = BK_ARG;
                  end
               end
            end
            BK_ARG: begin
               out_valid_in = 1'b1;
               out_byte_in  = shift_ff[63:56];
               out_last_in  = (rem_ff == 4'd1);
               shift_in     = {shift_ff[55:0], 8'h00};
               rem_in       = rem_ff - 4'd1;
               if (rem_ff == 4'd1) begin
                  state_in = BK_HEAD;
               end
            end
            default: state_in = BK_HEAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_HEAD;
         rem_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

// File: hw/rtl/cbor_item_encoder_unit.sv
// channel | direction | handshake           | beat
// req     | in        | req_push / req_full | req_cmd, req_operand
// rsp     | out       | rsp_pop / rsp_empty | rsp_out_byte, rsp_last
//
// One output byte per cycle from the byte sequencer while its output is free:
// a token is 1 to 9 bytes (1 + argument bytes); a double or 8-byte header is 9.
// The classifier accepts a token every cycle while the descriptor queue
// (DEPTH entries) has room; req_full rises when it is full.
// Reset is synchronous and clears the queue, sequencer state and output valid flag.
// With rsp_pop low the output register holds and the queue fills behind it.

`include "assert_macros.svh"

module cbor_item_encoder_unit
   import cie_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_operand,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   desc_type       enq_data, deq_data;
   logic           enq, deq;
   queue_stat_type q_stat;
   back_stat_type  b_stat;

   assign req_full = q_stat.full;

   cie_front u_front (
      .req_push    (req_push),
      .req_cmd     (req_cmd),
      .req_operand (req_operand),
      .q_full      (q_stat.full),
      .q_push      (enq),
      .q_data      (enq_data)
   );

   cie_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (enq),
      .push_data (enq_data),
      .pop       (deq),
      .pop_data  (deq_data),
      .stat      (q_stat)
   );

   cie_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_data       (deq_data),
      .q_empty      (q_stat.empty),
      .q_pop        (deq),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .stat         (b_stat)
   );

   `ASSERT_ALWAYS(a_queue_flags, clock, reset, !(q_stat.full && q_stat.empty), "queue full and empty")
   `ASSERT_SAME(a_arg_count, clock, reset, b_stat.arg_phase, (b_stat.remaining != 4'd0) && (b_stat.remaining <= 4'd8), "bad argument byte count")
   `ASSERT_NEXT(a_token_continues, clock, reset, rsp_pop && !rsp_empty && !rsp_last, b_stat.arg_phase || !rsp_empty, "token cut short")

endmodule

// File: tb/cbor_item_encoder_checker.sv
module cbor_item_encoder_checker
   import cie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_operand,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
   } enc_byte_type;

   enc_byte_type expected_bytes[$];

   function automatic void emit(logic [7:0] b);
      enc_byte_type e;
      e.out_byte = b;
      e.last = 1'b0;
      expected_bytes.insert(expected_bytes.size(), e);
   endfunction

   function automatic void emit_be(logic [63:0] v, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) begin
         emit(v[i*8 +: 8]);
      end
   endfunction

   function automatic void emit_head(logic [2:0] major, logic [63:0] n);
      if (n < 64'd24) begin
         emit({major, n[4:0]});
      end else if (n < 64'd256) begin
         emit({major, AI_ONE_BYTE});
         emit_be(n, 1);
      end else if (n < 64'd65536) begin
         emit({major, AI_TWO_BYTES});
         emit_be(n, 2);
      end else if (n < 64'd4294967296) begin
         emit({major, AI_FOUR_BYTES});
         emit_be(n, 4);
      end else begin
         emit({major, AI_EIGHT_BYTES});
         emit_be(n, 8);
      end
   endfunction

   function automatic void encode_token(logic [2:0] cmd, logic [63:0] operand);
      case (cmd_type'(cmd))
         CMD_UNSIGNED:  emit_head(MAJOR_UNSIGNED, operand);
         CMD_DOUBLE: begin
            emit(HEAD_DOUBLE);
            emit_be(operand, 8);
         end
         CMD_TEXT_HDR:  emit_head(MAJOR_TEXT, operand);
         CMD_BYTES_HDR: emit_head(MAJOR_BYTES, operand);
         CMD_BOOL:      emit(operand[0] ? HEAD_TRUE : HEAD_FALSE);
         CMD_ARRAY_HDR: emit_head(MAJOR_ARRAY, operand);
         CMD_MAP_HDR:   emit_head(MAJOR_MAP, operand);
         default:       emit(operand[7:0]);
      endcase
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      enc_byte_type want;
      if (reset) begin
         fail_count = 0;
         pending_beats = 0;
      end else begin
         if (req_push && !req_full) begin
            encode_token(req_cmd, req_operand);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected beat: out_byte %02h last %0b", rsp_out_byte, rsp_last);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         pending_beats = expected_bytes.size();
      end
   end

endmodule

// File: tb/tb_cbor_item_encoder_unit.sv
module tb_cbor_item_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import cie_pkg::*;

   localparam int RANDOM_TOKENS = 200;
   localparam int QUIET_TOKENS  = 40;
   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_cmd = CMD_UNSIGNED;
   logic [63:0] req_operand = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   int fail_count;
   int pending_beats;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_off_req = 1'b0;
   bit hold_done = 1'b0;

   always #5 clock = ~clock;

   cbor_item_encoder_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_cmd      (req_cmd),
      .req_operand  (req_operand),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   cbor_item_encoder_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_operand   (req_operand),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("cbor_item_encoder_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_token(cmd_type cmd, logic [63:0] operand);
      req_cmd <= cmd;
      req_operand <= operand;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] pick_operand();
      logic [63:0] edges[9];
      edges = '{64'd23, 64'd24, 64'd255, 64'd256, 64'd65535, 64'd65536,
                64'hffff_ffff, 64'h1_0000_0000, '1};
      case ($urandom_range(0, 5))
         0: return 64'($urandom_range(0, 23));
         1: return 64'($urandom_range(24, 255));
         2: return 64'($urandom_range(256, 65535));
         3: return {32'h0, $urandom};
         4: return {$urandom, $urandom};
         default: return edges[$urandom_range(0, 8)];
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_token(CMD_UNSIGNED, 64'd0);
      send_token(CMD_UNSIGNED, 64'd23);
      send_token(CMD_UNSIGNED, 64'd24);
      send_token(CMD_UNSIGNED, 64'd255);
      send_token(CMD_UNSIGNED, 64'd256);
      send_token(CMD_UNSIGNED, 64'd65535);
      send_token(CMD_UNSIGNED, 64'd65536);
      send_token(CMD_UNSIGNED, 64'hffff_ffff);
      send_token(CMD_UNSIGNED, 64'h1_0000_0000);
      send_token(CMD_UNSIGNED, '1);
      send_token(CMD_DOUBLE, 64'h0);
      send_token(CMD_DOUBLE, '1);
      send_token(CMD_DOUBLE, 64'h4009_21fb_5444_2d18);
      send_token(CMD_TEXT_HDR, 64'd23);
      send_token(CMD_TEXT_HDR, 64'd24);
      send_token(CMD_BYTES_HDR, 64'd300);
      send_token(CMD_BOOL, 64'd1);
      send_token(CMD_BOOL, 64'd0);
      send_token(CMD_BOOL, 64'hffff_ffff_ffff_fffe);
      send_token(CMD_BOOL, '1);
      send_token(CMD_ARRAY_HDR, 64'd70000);
      send_token(CMD_MAP_HDR, 64'h100_0000_0000);
      send_token(CMD_PAYLOAD, 64'h0);
      send_token(CMD_PAYLOAD, 64'hffff_ffff_ffff_ff00);
      send_token(CMD_PAYLOAD, 64'hdead_beef_0000_00a5);

      for (int i = 0; i < RANDOM_TOKENS; i++) begin
         if (i == 60) hold_off_req = 1'b1;
         if (i == RANDOM_TOKENS - QUIET_TOKENS) quiet = 1'b1;
         send_token(cmd_type'($urandom_range(0, 7)), pick_operand());
      end
      req_push <= 1'b0;

      while (pending_beats != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("cbor_item_encoder_unit: match");
      end else begin
         $display("cbor_item_encoder_unit: mismatch");
      end
      $finish;
   end

   // receiver: random stalls, one long hold-off so the input backs up
   initial begin
      @(negedge reset);
      forever begin
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cie_pkg.sv
hw/rtl/cie_front.sv
hw/rtl/cie_queue.sv
hw/rtl/cie_back.sv
hw/rtl/cbor_item_encoder_unit.sv
tb/cbor_item_encoder_checker.sv
tb/tb_cbor_item_encoder_unit.sv
